FILE: hdl/rfce_pkg.sv
// ----------------------------------------------------------------------------
// RF fan command pulse encoder package
// Shared types, constants and code tables for the fan remote pulse encoder.
// ----------------------------------------------------------------------------
package rfce_pkg;

    // Slot configuration
    localparam int MAX_FANS      = 4;
    localparam int NUM_SLOTS     = 4;
    localparam int SLOT_IDX_W    = 2;

    // Field widths
    localparam int SLOT_W        = 3;
    localparam int CMD_W         = 3;
    localparam int ID_W          = 5;
    localparam int COUNT_W       = 3;
    localparam int DUR_W         = 14;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 5;

    // Code word layout: the id followed by the command code, MSB aligned
    localparam int NARROW_BITS   = 7;
    localparam int WIDE_BITS     = 19;
    localparam int WORD_W        = ID_W + WIDE_BITS;
    localparam int NARROW_WORD_W = ID_W + NARROW_BITS;
    localparam int BITS_LEFT_W   = $clog2(WORD_W + 1);

    // Pulse durations in microseconds
    localparam logic [DUR_W-1:0] DUR_SYNC_SPACE = 14'd8900;
    localparam logic [DUR_W-1:0] DUR_SHORT_MARK = 14'd336;
    localparam logic [DUR_W-1:0] DUR_LONG_MARK  = 14'd689;
    localparam logic [DUR_W-1:0] DUR_ZERO_SPACE = 14'd658;
    localparam logic [DUR_W-1:0] DUR_ONE_SPACE  = 14'd321;
    localparam logic [DUR_W-1:0] DUR_NONE       = 14'd0;

    // Job queue between the front and the back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TX_ENABLED = 3'd0,
        REG_FAN_COUNT  = 3'd1,
        REG_FAN_ID0    = 3'd2,
        REG_FAN_ID1    = 3'd3,
        REG_FAN_ID2    = 3'd4,
        REG_FAN_ID3    = 3'd5,
        REG_WIDE_MASK  = 3'd6
    } cfg_reg_t;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NO_TX    = 2'd1,
        ERR_BAD_SLOT = 2'd2
    } err_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERROR,
        BK_SYNC_SPACE,
        BK_SYNC_MARK,
        BK_BIT_SPACE,
        BK_BIT_MARK
    } back_state_t;

    // Input transaction
    typedef struct packed {
        logic [SLOT_W-1:0] fan_slot;
        logic [CMD_W-1:0]  command;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic             pulse_level;
        logic [DUR_W-1:0] duration_us;
        logic             last_pulse;
        logic [1:0]       error_code;
    } out_item_t;

    // Classified job handed from the front to the back
    typedef struct packed {
        err_t              err;
        logic              wide;
        logic [WORD_W-1:0] word;
    } job_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // 7-bit command table
    function automatic logic [NARROW_BITS-1:0] narrow_code(input logic [CMD_W-1:0] cmd);
        logic [NARROW_BITS-1:0] code;
        unique case (cmd)
            3'd0: code = 7'h02;
            3'd1: code = 7'h08;
            3'd2: code = 7'h0A;
            3'd3: code = 7'h10;
            3'd4: code = 7'h18;
            3'd5: code = 7'h22;
            3'd6: code = 7'h20;
            3'd7: code = 7'h04;
            default: code = 7'h02;
        endcase
        return code;
    endfunction

    // 19-bit command table
    function automatic logic [WIDE_BITS-1:0] wide_code(input logic [CMD_W-1:0] cmd);
        logic [WIDE_BITS-1:0] code;
        unique case (cmd)
            3'd0: code = 19'h3A1DF;
            3'd1: code = 19'h3A13F;
            3'd2: code = 19'h3A167;
            3'd3: code = 19'h3A1BF;
            3'd4: code = 19'h3A1AF;
            3'd5: code = 19'h3A16B;
            3'd6: code = 19'h3A17F;
            3'd7: code = 19'h3A12F;
            default: code = 19'h3A1DF;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/rfce_front.sv
// ----------------------------------------------------------------------------
// RF fan command pulse encoder front end
// Holds the configuration registers, accepts commands and classifies each
// one into an error job or a code word job for the queue.
// ----------------------------------------------------------------------------
module rfce_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rfce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rfce_pkg::in_item_t            in_data,
    input  rfce_pkg::queue_status_t       q_status,
    output logic                          push,
    output rfce_pkg::job_t                push_job
);
    import rfce_pkg::*;

    logic                 tx_enabled_reg;
    logic [COUNT_W-1:0]   fan_count_reg;
    logic [ID_W-1:0]      fan_id_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] wide_mask_reg;

    logic [COUNT_W-1:0]    slot_count;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic                  slot_bad;
    logic                  wide;
    logic [ID_W-1:0]       fan_id;

    // Configuration register writes; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_enabled_reg <= 1'b0;
            fan_count_reg  <= '0;
            wide_mask_reg  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                fan_id_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TX_ENABLED: tx_enabled_reg <= cfg_data[0];
                REG_FAN_COUNT:  fan_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_FAN_ID0:    fan_id_reg[0]  <= cfg_data[ID_W-1:0];
                REG_FAN_ID1:    fan_id_reg[1]  <= cfg_data[ID_W-1:0];
                REG_FAN_ID2:    fan_id_reg[2]  <= cfg_data[ID_W-1:0];
                REG_FAN_ID3:    fan_id_reg[3]  <= cfg_data[ID_W-1:0];
                REG_WIDE_MASK:  wide_mask_reg  <= cfg_data[NUM_SLOTS-1:0];
                default:        ;
            endcase
        end
    end

    // Effective slot count saturates at the number of supported fans.
    assign slot_count = (fan_count_reg > COUNT_W'(MAX_FANS)) ? COUNT_W'(MAX_FANS)
                                                             : fan_count_reg;
    assign slot_bad   = (in_data.fan_slot >= slot_count) ||
                        (in_data.fan_slot >= SLOT_W'(NUM_SLOTS));
    assign slot_idx   = in_data.fan_slot[SLOT_IDX_W-1:0];
    assign wide       = wide_mask_reg[slot_idx];
    assign fan_id     = fan_id_reg[slot_idx];

    // Classify the command and build the MSB-aligned code word.
    always_comb
    begin
        push_job.wide = wide;
        if (wide)
        begin
            push_job.word = {fan_id, wide_code(in_data.command)};
        end
        else
        begin
            push_job.word = {fan_id, narrow_code(in_data.command),
                             (WORD_W - NARROW_WORD_W)'(0)};
        end
        priority if (!tx_enabled_reg)
        begin
            push_job.err = ERR_NO_TX;
        end
        else if (slot_bad)
        begin
            push_job.err = ERR_BAD_SLOT;
        end
        else
        begin
            push_job.err = ERR_NONE;
        end
    end

    // A transaction is taken whenever the queue has room.
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

FILE: hdl/rfce_queue.sv
// ----------------------------------------------------------------------------
// RF fan command pulse encoder job queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module rfce_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rfce_pkg::job_t          push_job,
    input  logic                    pop,
    output rfce_pkg::job_t          pop_job,
    output rfce_pkg::queue_status_t status
);
    import rfce_pkg::*;

    job_t                entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = entries_reg[rd_ptr_reg];

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/rfce_back.sv
// ----------------------------------------------------------------------------
// RF fan command pulse encoder back end
// Sequencer that takes jobs from the queue and emits one pulse per cycle
// into a registered output stage while the output is not stalled.
// ----------------------------------------------------------------------------
module rfce_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rfce_pkg::queue_status_t q_status,
    input  rfce_pkg::job_t          pop_job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output rfce_pkg::out_item_t     out_data
);
    import rfce_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [WORD_W-1:0]      shift_reg;
    logic [BITS_LEFT_W-1:0] bits_left_reg;
    err_t                   err_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic      advance;
    logic      emit;
    logic      cur_bit;
    logic      last_bit;
    out_item_t pulse;

    assign advance  = !out_valid_reg || !out_stall;
    assign cur_bit  = shift_reg[WORD_W-1];
    assign last_bit = (bits_left_reg == BITS_LEFT_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (pop_job.err != ERR_NONE) ? BK_ERROR : BK_SYNC_SPACE;
                end
            end
            BK_ERROR:      if (advance) state_next = BK_IDLE;
            BK_SYNC_SPACE: if (advance) state_next = BK_SYNC_MARK;
            BK_SYNC_MARK:  if (advance) state_next = BK_BIT_SPACE;
            BK_BIT_SPACE:  if (advance) state_next = BK_BIT_MARK;
            BK_BIT_MARK:   if (advance) state_next = last_bit ? BK_IDLE : BK_BIT_SPACE;
            default:       state_next = BK_IDLE;
        endcase
    end

    // Pulse generation and queue pop.
    always_comb
    begin
        emit              = 1'b0;
        pop               = 1'b0;
        pulse.pulse_level = 1'b0;
        pulse.duration_us = DUR_NONE;
        pulse.last_pulse  = 1'b0;
        pulse.error_code  = ERR_NONE;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !q_status.empty;
            end
            BK_ERROR:
            begin
                emit             = advance;
                pulse.last_pulse = 1'b1;
                pulse.error_code = err_reg;
            end
            BK_SYNC_SPACE:
            begin
                emit              = advance;
                pulse.duration_us = DUR_SYNC_SPACE;
            end
            BK_SYNC_MARK:
            begin
                emit              = advance;
                pulse.pulse_level = 1'b1;
                pulse.duration_us = DUR_SHORT_MARK;
            end
            BK_BIT_SPACE:
            begin
                emit              = advance;
                pulse.duration_us = cur_bit ? DUR_ONE_SPACE : DUR_ZERO_SPACE;
            end
            BK_BIT_MARK:
            begin
                emit              = advance;
                pulse.pulse_level = 1'b1;
                pulse.duration_us = cur_bit ? DUR_LONG_MARK : DUR_SHORT_MARK;
                pulse.last_pulse  = last_bit;
            end
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Job registers: load on pop, shift after each bit's mark pulse.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            shift_reg     <= pop_job.word;
            err_reg       <= pop_job.err;
            bits_left_reg <= pop_job.wide ? BITS_LEFT_W'(WORD_W) : BITS_LEFT_W'(NARROW_WORD_W);
        end
        else if (emit && (state_reg == BK_BIT_MARK))
        begin
            shift_reg     <= {shift_reg[WORD_W-2:0], 1'b0};
            bits_left_reg <= bits_left_reg - 1'b1;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= pulse;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/rf_fan_command_pulse_encoder.sv
// ----------------------------------------------------------------------------
// RF fan command pulse encoder
// Turns fan commands into on-off-keyed pulse-width trains for a fan remote.
// ----------------------------------------------------------------------------
// Usage:
//   Configure through cfg_wr_en/cfg_index/cfg_data while the block is idle.
//   Each input transaction (in_valid, in_stall, in_data) names a fan slot and
//   a command. Each output transaction (out_valid, out_stall, out_data) is one
//   pulse: a sync space/mark pair, then one space/mark pair per code bit.
//   A 7-bit slot gives 26 pulses and a 19-bit slot 50; the final pulse has
//   last_pulse set. A refused command gives a single error transaction.
// Sequencing:
//   An accepted command is written into the two-entry queue; the sequencer
//   loads each job from the queue in its idle state and then emits one pulse
//   per cycle while the output is not stalled, through the output register.
//   Commands keep being accepted while the queue has room.
// Reset and stall:
//   Reset clears the configuration, the queue and the sequencer. While the
//   receiver stalls, the output register holds its pulse and the sequencer
//   waits; in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module rf_fan_command_pulse_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rfce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rfce_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rfce_pkg::out_item_t              out_data
);
    import rfce_pkg::*;

    queue_status_t q_status;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          pop_job;

    // Front: configuration and classification.
    rfce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    // Job queue.
    rfce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // Back: pulse sequencer and output register.
    rfce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_job   (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: hdl/rfce_checker.sv
// ----------------------------------------------------------------------------
// RF fan command pulse encoder checker
// Port-level assertions on the pulse stream, bound to the top level.
// ----------------------------------------------------------------------------
module rfce_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input rfce_pkg::out_item_t out_data
);
    import rfce_pkg::*;

    // A stalled pulse stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    // An error transaction is a lone zero-length final space.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.error_code != ERR_NONE) |->
            out_data.last_pulse && (out_data.duration_us == DUR_NONE) &&
            !out_data.pulse_level)
        else $error("malformed error transaction");

    // Marks of a good train are short or long marks only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.error_code == ERR_NONE) && out_data.pulse_level |->
            (out_data.duration_us == DUR_SHORT_MARK) ||
            (out_data.duration_us == DUR_LONG_MARK))
        else $error("bad mark duration");

    // A good train ends on a mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.error_code == ERR_NONE) && out_data.last_pulse |->
            out_data.pulse_level)
        else $error("train does not end on a mark");

endmodule

bind rf_fan_command_pulse_encoder rfce_checker u_rfce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
